/* hw/rtl/src_pkg.sv */
package src_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_EXP_COMMAND = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_EXP_LENGTH  = 1'd1;

  localparam int unsigned ByteW = 8;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_SIZE_BAD = 2'd1,
    STATUS_CMD_BAD  = 2'd2,
    STATUS_CSUM_BAD = 2'd3
  } status_e;

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data;
    logic             is_payload;
    logic             frame_done;
    status_e          status;
  } result_t;

endpackage

/* hw/rtl/serial_response_checker.sv */
// Latency: a result appears on the outputs the cycle after its byte transfer.
// Throughput: one byte per cycle; the output register lets a new byte enter
// whenever the held result is being taken or none is held.
// Header, size and command bytes produce no result.
// Reset (rst_ni low, asynchronous): frame position, checksum, error flags,
// output valid and both configuration registers go to zero.
module serial_response_checker #(
  parameter int unsigned HEADER_BYTES = 3
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [src_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [src_pkg::ByteW-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [src_pkg::ByteW-1:0]   in_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [src_pkg::ByteW-1:0]   out_byte_o,
  output logic                        is_payload_o,
  output logic                        frame_done_o,
  output src_pkg::status_e            status_o
);
  import src_pkg::*;

  logic [ByteW-1:0] exp_cmd_q, exp_len_q;
  result_t          res;
  result_t          out_q, out_d;
  logic             take;

  assign in_ready_o = !out_q.valid || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  src_frame_track #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_track (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .byte_i       (in_byte_i),
    .exp_command_i(exp_cmd_q),
    .exp_length_i (exp_len_q),
    .result_o     (res)
  );

  always_comb begin
    out_d = out_q;
    if (take) begin
      out_d = res;
    end else if (out_ready_i) begin
      out_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q     <= '0;
      exp_cmd_q <= '0;
      exp_len_q <= '0;
    end else begin
      out_q <= out_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_EXP_COMMAND: exp_cmd_q <= cfg_wdata_i;
          CFG_EXP_LENGTH:  exp_len_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  assign out_valid_o  = out_q.valid;
  assign out_byte_o   = out_q.data;
  assign is_payload_o = out_q.is_payload;
  assign frame_done_o = out_q.frame_done;
  assign status_o     = out_q.status;

  check_kind_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_payload_o != frame_done_o))
    else $error("result is neither or both payload and status");

  check_status_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_payload_o) |-> (status_o == STATUS_OK))
    else $error("nonzero status on a payload result");

  check_status_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_done_o) |-> (out_byte_o == '0))
    else $error("status result carries a nonzero byte");

  check_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with an empty output register");

endmodule

/* hw/rtl/src_frame_track.sv */
module src_frame_track #(
  parameter int unsigned HEADER_BYTES = 3
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     take_i,
  input  logic [src_pkg::ByteW-1:0] byte_i,
  input  logic [src_pkg::ByteW-1:0] exp_command_i,
  input  logic [src_pkg::ByteW-1:0] exp_length_i,
  output src_pkg::result_t         result_o
);
  import src_pkg::*;

  localparam int unsigned MaxPos = HEADER_BYTES + 2 + (1 << ByteW);
  localparam int unsigned PosW   = $clog2(MaxPos + 1);
  localparam logic [PosW-1:0] SizePos  = PosW'(HEADER_BYTES);
  localparam logic [PosW-1:0] CmdPos   = PosW'(HEADER_BYTES + 1);
  localparam logic [PosW-1:0] DataPos  = PosW'(HEADER_BYTES + 2);

  logic [PosW-1:0]  pos_q, pos_d;
  logic [ByteW-1:0] xor_q, xor_d;
  logic             size_bad_q, size_bad_d;
  logic             cmd_bad_q, cmd_bad_d;
  logic [PosW-1:0]  data_ofs;

  assign data_ofs = pos_q - DataPos;

  always_comb begin
    pos_d      = pos_q;
    xor_d      = xor_q;
    size_bad_d = size_bad_q;
    cmd_bad_d  = cmd_bad_q;
    result_o   = '0;
    if (take_i) begin
      if (pos_q < SizePos) begin
        pos_d = pos_q + PosW'(1);
      end else if (pos_q == SizePos) begin
        size_bad_d = (byte_i != exp_length_i);
        xor_d      = byte_i;
        pos_d      = pos_q + PosW'(1);
      end else if (pos_q == CmdPos) begin
        cmd_bad_d = (byte_i != exp_command_i);
        xor_d     = xor_q ^ byte_i;
        pos_d     = pos_q + PosW'(1);
      end else if (data_ofs < PosW'(exp_length_i)) begin
        xor_d               = xor_q ^ byte_i;
        pos_d               = pos_q + PosW'(1);
        result_o.valid      = 1'b1;
        result_o.data       = byte_i;
        result_o.is_payload = 1'b1;
      end else begin
        // checksum byte closes the frame
        result_o.valid      = 1'b1;
        result_o.frame_done = 1'b1;
        if (size_bad_q) begin
          result_o.status = STATUS_SIZE_BAD;
        end else if (cmd_bad_q) begin
          result_o.status = STATUS_CMD_BAD;
        end else if (xor_q != byte_i) begin
          result_o.status = STATUS_CSUM_BAD;
        end else begin
          result_o.status = STATUS_OK;
        end
        pos_d      = '0;
        xor_d      = '0;
        size_bad_d = 1'b0;
        cmd_bad_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      xor_q      <= '0;
      size_bad_q <= 1'b0;
      cmd_bad_q  <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      xor_q      <= xor_d;
      size_bad_q <= size_bad_d;
      cmd_bad_q  <= cmd_bad_d;
    end
  end

  check_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosW'(MaxPos))
    else $error("frame position ran past the longest frame");

  check_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.frame_done) |=> (pos_q == '0 && !size_bad_q && !cmd_bad_q))
    else $error("frame state not cleared after the checksum byte");

  check_no_result_in_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_i && pos_q <= CmdPos) |-> !result_o.valid)
    else $error("result produced for a header, size or command byte");

endmodule
